// ===== sv/dfs_cw_pkg.sv =====
// Package with the sizes, codes and control types of the depth-first component walker.
package dfs_cw_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int ENTRY_SLOTS = 2 * MAX_EDGES;
    localparam int NODE_SLOTS  = MAX_NODES + 1;

    localparam int NODE_W = 11;
    localparam int PTR_W  = 14;
    localparam int ENT_AW = 13;
    localparam int STK_AW = 10;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_NEXT     = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_CLR_BOOT,
        S_IDLE,
        S_CLR_INIT,
        S_CLR,
        S_E_CHK,
        S_E_A0,
        S_E_B0,
        S_E_A1,
        S_E_B1,
        S_POP_CHK,
        S_CUR_EVAL,
        S_ENT_USE,
        S_SEEN_P,
        S_SEEN_S,
        S_PUSH,
        S_FIN
    } state_t;

    typedef struct packed {
        logic item_load;
        logic clr_init;
        logic clr_step;
        logic edge_rd;
        logic edge_wr;
        logic edge_side;
        logic cur_rd;
        logic pop;
        logic ent_rd;
        logic ent_use;
        logic scan_rd;
        logic visit;
        logic set_start;
        logic push;
        logic set_done;
        logic set_range;
        logic set_full;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            bad_range;
        logic            full;
        logic            depth_zero;
        logic            cursor_zero;
        logic            seen;
        logic            scan_ok;
        logic            clr_last;
    } dp_stat_t;

endpackage

// ===== sv/dfs_cw_if.sv =====
// Item channel interfaces for requests and results.
interface dfs_cw_in_if import dfs_cw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [NODE_W-1:0] end_a;
    logic [NODE_W-1:0] end_b;

    modport source (output valid, opcode, end_a, end_b, input ready);
    modport sink (input valid, opcode, end_a, end_b, output ready);
endinterface

interface dfs_cw_out_if import dfs_cw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node;
    logic              starts_component;
    logic              done_res;
    logic [STAT_W-1:0] status;

    modport source (output valid, node, starts_component, done_res, status, input ready);
    modport sink (input valid, node, starts_component, done_res, status, output ready);
endinterface

// ===== sv/dfs_cw_dp.sv =====
// Datapath: graph memories, walk stack, counters and result registers.
module dfs_cw_dp import dfs_cw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [OP_W-1:0]   in_opcode,
    input  logic [NODE_W-1:0] in_end_a,
    input  logic [NODE_W-1:0] in_end_b,
    input  logic [NODE_W-1:0] node_count,
    output logic [NODE_W-1:0] out_node,
    output logic              out_starts,
    output logic              out_done,
    output logic [STAT_W-1:0] out_status
);

    localparam logic [NODE_W-1:0] NODE_MAX  = NODE_W'(MAX_NODES);
    localparam logic [PTR_W-1:0]  USED_LIM  = PTR_W'(ENTRY_SLOTS - 2);
    localparam logic [NODE_W-1:0] DEPTH_MAX = NODE_W'(MAX_NODES);

    logic [PTR_W-1:0]  head_mem [NODE_SLOTS];
    logic [PTR_W-1:0]  tail_mem [NODE_SLOTS];
    logic              seen_mem [NODE_SLOTS];
    logic [NODE_W-1:0] nb_mem   [ENTRY_SLOTS];
    logic [PTR_W-1:0]  link_mem [ENTRY_SLOTS];
    logic [PTR_W-1:0]  cur_mem  [MAX_NODES];

    logic [NODE_W-1:0] a_reg, b_reg, cand_reg;
    logic [PTR_W-1:0]  used_reg, used_next;
    logic [NODE_W-1:0] depth_reg, depth_next;
    logic [NODE_W-1:0] scan_reg, scan_next;
    logic [NODE_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0]  head_q, tail_q, link_q, cur_q;
    logic [NODE_W-1:0] nb_q;
    logic              seen_q;
    logic [NODE_W-1:0] res_node_reg;
    logic              res_start_reg, res_done_reg;
    logic [STAT_W-1:0] res_status_reg;

    logic [NODE_W-1:0] owner, other, limit;
    logic [PTR_W-1:0]  new_ptr, tail_m1, cur_m1;
    logic [NODE_W-1:0] depth_m1;

    logic              head_we, tail_we, seen_we, link_we, cur_we, seen_wd;
    logic [NODE_W-1:0] head_wa, tail_wa, seen_wa, seen_ra;
    logic [PTR_W-1:0]  head_wd, tail_wd, link_wd, cur_wd;
    logic [ENT_AW-1:0] link_wa;
    logic [STK_AW-1:0] cur_wa;

    assign owner    = cmd.edge_side ? b_reg : a_reg;
    assign other    = cmd.edge_side ? a_reg : b_reg;
    assign new_ptr  = used_reg + PTR_W'(1);
    assign tail_m1  = tail_q - PTR_W'(1);
    assign cur_m1   = cur_q - PTR_W'(1);
    assign depth_m1 = depth_reg - NODE_W'(1);
    assign limit    = (node_count > NODE_MAX) ? NODE_MAX : node_count;

    always_comb
    begin
        head_we = 1'b0;
        head_wa = cand_reg;
        head_wd = new_ptr;
        tail_we = 1'b0;
        tail_wa = owner;
        tail_wd = new_ptr;
        seen_we = 1'b0;
        seen_wa = cand_reg;
        seen_wd = 1'b1;
        seen_ra = scan_reg;
        link_we = 1'b0;
        link_wa = used_reg[ENT_AW-1:0];
        link_wd = '0;
        cur_we  = 1'b0;
        cur_wa  = depth_m1[STK_AW-1:0];
        cur_wd  = link_q;
        if (cmd.clr_step)
        begin
            head_we = 1'b1;
            head_wa = clr_cnt_reg;
            head_wd = '0;
            tail_we = 1'b1;
            tail_wa = clr_cnt_reg;
            tail_wd = '0;
            seen_we = 1'b1;
            seen_wa = clr_cnt_reg;
            seen_wd = 1'b0;
        end
        if (cmd.edge_rd)
        begin
            link_we = 1'b1;
        end
        if (cmd.edge_wr)
        begin
            tail_we = 1'b1;
            if (tail_q == '0)
            begin
                head_we = 1'b1;
                head_wa = owner;
            end
            else
            begin
                link_we = 1'b1;
                link_wa = tail_m1[ENT_AW-1:0];
                link_wd = new_ptr;
            end
        end
        if (cmd.ent_use)
        begin
            cur_we  = 1'b1;
            seen_ra = nb_q;
        end
        if (cmd.visit)
        begin
            seen_we = 1'b1;
        end
        if (cmd.push && depth_reg < DEPTH_MAX)
        begin
            cur_we = 1'b1;
            cur_wa = depth_reg[STK_AW-1:0];
            cur_wd = head_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        if (cmd.visit)
            head_q <= head_mem[cand_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
            tail_mem[tail_wa] <= tail_wd;
        if (cmd.edge_rd)
            tail_q <= tail_mem[owner];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_wa] <= seen_wd;
        if (cmd.ent_use || cmd.scan_rd)
            seen_q <= seen_mem[seen_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_rd)
            nb_mem[used_reg[ENT_AW-1:0]] <= other;
        if (cmd.ent_rd)
            nb_q <= nb_mem[cur_m1[ENT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (cmd.ent_rd)
            link_q <= link_mem[cur_m1[ENT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[cur_wa] <= cur_wd;
        if (cmd.cur_rd)
            cur_q <= cur_mem[depth_m1[STK_AW-1:0]];
    end

    always_comb
    begin
        used_next    = used_reg;
        depth_next   = depth_reg;
        scan_next    = scan_reg;
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_init)
        begin
            used_next    = '0;
            depth_next   = '0;
            scan_next    = NODE_W'(1);
            clr_cnt_next = '0;
        end
        if (cmd.clr_step)
            clr_cnt_next = clr_cnt_reg + NODE_W'(1);
        if (cmd.edge_wr)
            used_next = new_ptr;
        if (cmd.pop)
            depth_next = depth_m1;
        if (cmd.push && depth_reg < DEPTH_MAX)
            depth_next = depth_reg + NODE_W'(1);
        if (cmd.scan_rd)
            scan_next = scan_reg + NODE_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            depth_reg   <= '0;
            scan_reg    <= NODE_W'(1);
            clr_cnt_reg <= '0;
        end
        else
        begin
            used_reg    <= used_next;
            depth_reg   <= depth_next;
            scan_reg    <= scan_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            a_reg          <= in_end_a;
            b_reg          <= in_end_b;
            res_node_reg   <= '0;
            res_start_reg  <= 1'b0;
            res_done_reg   <= 1'b0;
            res_status_reg <= ST_OK;
        end
        if (cmd.ent_use)
            cand_reg <= nb_q;
        if (cmd.scan_rd)
            cand_reg <= scan_reg;
        if (cmd.visit)
        begin
            res_node_reg  <= cand_reg;
            res_start_reg <= cmd.set_start;
        end
        if (cmd.set_done)
            res_done_reg <= 1'b1;
        if (cmd.set_range)
            res_status_reg <= ST_RANGE;
        if (cmd.set_full)
            res_status_reg <= ST_FULL;
        if (cmd.out_load)
        begin
            out_node   <= res_node_reg;
            out_starts <= res_start_reg;
            out_done   <= res_done_reg;
            out_status <= res_status_reg;
        end
    end

    always_comb
    begin
        stat.opcode      = in_opcode;
        stat.bad_range   = (a_reg == '0) || (b_reg == '0) || (a_reg > NODE_MAX)
                           || (b_reg > NODE_MAX);
        stat.full        = used_reg > USED_LIM;
        stat.depth_zero  = depth_reg == '0;
        stat.cursor_zero = cur_q == '0;
        stat.seen        = seen_q;
        stat.scan_ok     = scan_reg <= limit;
        stat.clr_last    = clr_cnt_reg == NODE_MAX;
    end

endmodule

// ===== sv/dfs_cw_ctrl.sv =====
// Controller state machine that sequences edge loads, walk steps and clearing passes.
module dfs_cw_ctrl import dfs_cw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_BOOT:
                if (stat.clr_last)
                    state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                begin
                    unique case (stat.opcode)
                        OP_ADD_EDGE: state_next = S_E_CHK;
                        OP_NEXT:     state_next = S_POP_CHK;
                        OP_CLEAR:    state_next = S_CLR_INIT;
                        default:     state_next = S_FIN;
                    endcase
                end
            S_CLR_INIT:
                state_next = S_CLR;
            S_CLR:
                if (stat.clr_last)
                    state_next = S_FIN;
            S_E_CHK:
                state_next = (stat.bad_range || stat.full) ? S_FIN : S_E_A0;
            S_E_A0:
                state_next = S_E_B0;
            S_E_B0:
                state_next = S_E_A1;
            S_E_A1:
                state_next = S_E_B1;
            S_E_B1:
                state_next = S_FIN;
            S_POP_CHK:
                state_next = stat.depth_zero ? S_SEEN_S : S_CUR_EVAL;
            S_CUR_EVAL:
                state_next = stat.cursor_zero ? S_POP_CHK : S_ENT_USE;
            S_ENT_USE:
                state_next = S_SEEN_P;
            S_SEEN_P:
                state_next = stat.seen ? S_POP_CHK : S_PUSH;
            S_SEEN_S:
                state_next = S_PUSH;
            S_PUSH:
                state_next = S_FIN;
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_SEEN_S)
        begin
            state_next = S_SEEN_S;
        end
    end

    // The root scan shares S_SEEN_S: a scan read is issued there, which leaves a candidate
    // pending, and its seen bit is judged in the cycle after.
    logic scan_pend_reg, scan_pend_next;
    state_t scan_state_next;

    always_comb
    begin
        scan_pend_next  = 1'b0;
        scan_state_next = S_SEEN_S;
        if (scan_pend_reg && !stat.seen)
            scan_state_next = S_PUSH;
        else if (stat.scan_ok)
            scan_pend_next = 1'b1;
        else
            scan_state_next = S_FIN;
    end

    state_t state_final;

    always_comb
    begin
        state_final = state_next;
        if (state_reg == S_SEEN_S)
            state_final = scan_state_next;
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_CLR_BOOT:
                cmd.clr_step = 1'b1;
            S_IDLE:
                cmd.item_load = in_valid;
            S_CLR_INIT:
                cmd.clr_init = 1'b1;
            S_CLR:
                cmd.clr_step = 1'b1;
            S_E_CHK:
            begin
                cmd.set_range = stat.bad_range;
                cmd.set_full  = !stat.bad_range && stat.full;
            end
            S_E_A0:
                cmd.edge_rd = 1'b1;
            S_E_B0:
                cmd.edge_wr = 1'b1;
            S_E_A1:
            begin
                cmd.edge_rd   = 1'b1;
                cmd.edge_side = 1'b1;
            end
            S_E_B1:
            begin
                cmd.edge_wr   = 1'b1;
                cmd.edge_side = 1'b1;
            end
            S_POP_CHK:
                cmd.cur_rd = !stat.depth_zero;
            S_CUR_EVAL:
            begin
                cmd.pop    = stat.cursor_zero;
                cmd.ent_rd = !stat.cursor_zero;
            end
            S_ENT_USE:
                cmd.ent_use = 1'b1;
            S_SEEN_P:
                cmd.visit = !stat.seen;
            S_SEEN_S:
            begin
                if (scan_pend_reg && !stat.seen)
                begin
                    cmd.visit     = 1'b1;
                    cmd.set_start = 1'b1;
                end
                else if (stat.scan_ok)
                    cmd.scan_rd = 1'b1;
                else
                    cmd.set_done = 1'b1;
            end
            S_PUSH:
                cmd.push = 1'b1;
            S_FIN:
                cmd.out_load = out_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR_BOOT;
            out_valid_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_final;
            out_valid_reg <= out_valid_next;
            scan_pend_reg <= (state_reg == S_SEEN_S) ? scan_pend_next : 1'b0;
        end
    end

endmodule

// ===== sv/dfs_component_order_walker_core.sv =====
// Top level of the depth-first component walker: channels, register port and core units.
//
//  channel   | dir | handshake         | payload
//  in_item   | in  | valid/ready       | opcode, end_a, end_b
//  out_item  | out | valid/ready       | node, starts_component, done_res, status
//  apb       | in  | psel/penable/...  | node_count at any address
//
// An edge is checked, then written as two list entries, one per end, each as a read of the
// list tail followed by a write; the result is then handed over. A walk request tries list
// entries, pops finished nodes and scans root indices in turn until it finds a node to visit.
// After reset, and on each clear item, a clearing pass empties the node tables and seen
// flags, and no item is taken meanwhile. The result register lets the next item in while a
// result waits on out_item.ready.
module dfs_component_order_walker_core import dfs_cw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dfs_cw_in_if.sink         in_item,
    dfs_cw_out_if.source      out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [NODE_W-1:0] node_count_reg;
    logic              unused_addr;

    assign pready      = 1'b1;
    assign prdata      = APB_DW'(node_count_reg);
    assign unused_addr = ^paddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= '0;
        else if (psel && penable && pwrite && (unused_addr || !unused_addr))
            node_count_reg <= pwdata[NODE_W-1:0];
    end

    dfs_cw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dfs_cw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (in_item.opcode),
        .in_end_a   (in_item.end_a),
        .in_end_b   (in_item.end_b),
        .node_count (node_count_reg),
        .out_node   (out_item.node),
        .out_starts (out_item.starts_component),
        .out_done   (out_item.done_res),
        .out_status (out_item.status)
    );

endmodule
